FILE: design/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// No dependencies; imported by bitmap_slot_allocator_unit and bsa_checker.
package bsa_pkg;

    localparam int WORD_BITS  = 32;
    localparam int WORD_SHIFT = 5;
    localparam int CAP_W      = 9;
    localparam int SLOT_W     = 8;
    localparam int STAT_W     = 3;
    localparam int REQ_W      = 2;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE_ALL = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 3'd4;

    // result item; status lands in the low bits when packed
    typedef struct packed {
        logic [CAP_W-1:0]  active;
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

FILE: design/bitmap_slot_allocator_unit.sv
// Bitmap slot allocator: used bitmap held in a 32-bit-word memory plus an active count.
// Allocate checks one bitmap word per cycle up to the first with a free slot; free reads, tests
// and clears the addressed bit; free-all and reject cases go straight to the result. One item at a time.
// Word scan through the single-read-port bitmap memory sets the allocate rate (up to 8 words at 256 slots).
// Reset (i_rst_n low, synchronous) clears the count, capacity and the per-word valid bits,
// so the whole bitmap reads as zero at once; no clearing pass is needed.
module bitmap_slot_allocator_unit
    import bsa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write: capacity
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CAP_W-1:0]  i_cfg_data,
    // request stream
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [15:0]       i_s_tdata,   // [0] has_object, [8:1] slot_in, [15:9] zero
    input  logic [REQ_W-1:0]  i_s_tuser,   // [1:0] req_type
    // result stream
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [23:0]       o_m_tdata    // [2:0] status, [10:3] slot_out,
                                           // [19:11] active_after, [23:20] zero
);

    localparam int WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;  // allocate: one bitmap word per cycle
    localparam logic [1:0] S_FCHK = 2'd2;  // free: test and clear the addressed bit
    localparam logic [1:0] S_DONE = 2'd3;  // hand result to the output register

    // bitmap memory, one word per 32 slots; r_wvalid marks words written since clear
    logic [WORD_BITS-1:0] r_mem [WORDS];
    logic [WORDS-1:0]     r_wvalid, n_wvalid;
    logic [WORD_BITS-1:0] r_mem_q;
    logic                 r_mem_v;

    logic [1:0]           r_state, n_state;
    logic [CAP_W-1:0]     r_capacity;
    logic [CAP_W-1:0]     r_active, n_active;
    logic [AW-1:0]        r_daddr, n_daddr;   // word whose data is in r_mem_q
    logic [AW-1:0]        r_last, n_last;     // last word below capacity
    logic [WORD_SHIFT-1:0] r_bit, n_bit;      // bit to free
    t_result              r_res, n_res;
    t_result              r_out;
    logic                 r_out_valid;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    logic [CAP_W-1:0]     eff_cap;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] in_range;
    logic [WORD_BITS-1:0] free_bits;
    logic                 found;
    logic [WORD_SHIFT-1:0] found_idx;
    logic                 has_obj;
    logic [SLOT_W-1:0]    slot_in;
    logic                 out_free;

    assign has_obj  = i_s_tdata[0];
    assign slot_in  = i_s_tdata[8:1];
    assign eff_cap  = (int'(r_capacity) > SLOTS) ? CAP_W'(SLOTS) : r_capacity;
    assign word     = r_mem_v ? r_mem_q : '0;
    assign out_free = !r_out_valid || i_m_tready;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {4'b0, r_out};

    // lowest free slot within capacity in the current word
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            in_range[b] = int'({r_daddr, WORD_SHIFT'(b)}) < int'(eff_cap);
        end
        free_bits = ~word & in_range;
        found     = 1'b0;
        found_idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                found     = 1'b1;
                found_idx = WORD_SHIFT'(b);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_active = r_active;
        n_daddr  = r_daddr;
        n_last   = r_last;
        n_bit    = r_bit;
        n_res    = r_res;
        n_wvalid = r_wvalid;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_data  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_res.status = ST_OK;
                    n_res.slot   = '0;
                    n_res.active = r_active;
                    n_state      = S_DONE;
                    unique case (i_s_tuser)
                        REQ_ALLOC: begin
                            if (r_active < eff_cap) begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_daddr = '0;
                                n_last  = AW'((eff_cap - 1'b1) >> WORD_SHIFT);
                                n_state = S_SCAN;
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end
                        REQ_FREE: begin
                            if (!has_obj || r_active == '0) begin
                                n_res.status = ST_NULL;
                            end else if (CAP_W'(slot_in) >= eff_cap) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(slot_in >> WORD_SHIFT);
                                n_daddr = AW'(slot_in >> WORD_SHIFT);
                                n_bit   = slot_in[WORD_SHIFT-1:0];
                                n_state = S_FCHK;
                            end
                        end
                        REQ_FREE_ALL: begin
                            n_wvalid     = '0;
                            n_active     = '0;
                            n_res.active = '0;
                        end
                        default: ;  // unused kind: no operation
                    endcase
                end
            end
            S_SCAN: begin
                // prefetch the next word while this one is checked
                rd_en   = (r_daddr != r_last);
                rd_addr = r_daddr + 1'b1;
                if (found) begin
                    wr_en             = 1'b1;
                    wr_data           = word | (WORD_BITS'(1) << found_idx);
                    n_wvalid[r_daddr] = 1'b1;
                    n_active          = r_active + 1'b1;
                    n_res.active      = r_active + 1'b1;
                    n_res.slot        = SLOT_W'({r_daddr, found_idx});
                    n_state           = S_DONE;
                end else if (r_daddr == r_last) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_daddr = rd_addr;
                end
            end
            S_FCHK: begin
                if (word[r_bit]) begin
                    wr_en             = 1'b1;
                    wr_data           = word & ~(WORD_BITS'(1) << r_bit);
                    n_wvalid[r_daddr] = 1'b1;
                    n_active          = r_active - 1'b1;
                    n_res.active      = r_active - 1'b1;
                end else begin
                    n_res.status = ST_NOT_USED;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // bitmap memory: one read port with registered data, one write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mem_q <= r_mem[rd_addr];
            r_mem_v <= r_wvalid[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_daddr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_capacity  <= '0;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_wvalid <= n_wvalid;
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr <= n_daddr;
        r_last  <= n_last;
        r_bit   <= n_bit;
        r_res   <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

endmodule

FILE: design/bsa_checker.sv
// Port-level checks for bitmap_slot_allocator_unit, attached by bind.
// Depends on bsa_pkg for status codes and field widths.
module bsa_checker
    import bsa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    t_result res;
    assign res = o_m_tdata[19:0];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (res.status <= ST_NOT_USED && o_m_tdata[23:20] == 4'b0))
        else $error("bad status code or padding");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && res.status != ST_OK |-> res.slot == '0)
        else $error("slot granted on failed request");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> int'(res.active) <= SLOTS)
        else $error("active count beyond pool size");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

bind bitmap_slot_allocator_unit bsa_checker #(.SLOTS(SLOTS)) u_bsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
